### hdl/rsss_pkg.sv
`timescale 1ns / 1ps

package rsss_pkg;

  // Detected save kind of the scan.
  typedef enum logic [2:0] {
    KIND_NONE      = 3'd0,
    KIND_EEPROM    = 3'd1,
    KIND_SRAM      = 3'd2,
    KIND_FLASH     = 3'd3,
    KIND_FLASH_GEN = 3'd4
  } kind_t;

  typedef struct packed {
    kind_t kind;
    logic  big_flash;
    logic  clock_seen;
  } scan_st_t;

  localparam scan_st_t SCAN_ST_RESET = '{kind: KIND_NONE, big_flash: 1'b0, clock_seen: 1'b0};

  // Reported save type codes.
  localparam logic [1:0] SAVE_EEPROM = 2'd0;
  localparam logic [1:0] SAVE_SRAM   = 2'd1;
  localparam logic [1:0] SAVE_FLASH  = 2'd2;
  localparam logic [1:0] SAVE_NONE   = 2'd3;

  // First four bytes of each signature, little-endian.
  localparam logic [31:0] SIG_EEPR = 32'h5250_4545;  // "EEPR"
  localparam logic [31:0] SIG_SRAM = 32'h4D41_5253;  // "SRAM"
  localparam logic [31:0] SIG_FLAS = 32'h5341_4C46;  // "FLAS"
  localparam logic [31:0] SIG_SIIR = 32'h5249_4953;  // "SIIR"

  // Remaining bytes, little-endian.
  localparam logic [23:0] TAIL_EEPROM  = 24'h5F_4D4F;     // "OM_"
  localparam logic [7:0]  TAIL_SRAM    = 8'h5F;           // "_"
  localparam logic [31:0] TAIL_FLASH1M = 32'h5F4D_3148;   // "H1M_"
  localparam logic [31:0] TAIL_FL512_A = 32'h3231_3548;   // "H512"
  localparam logic [7:0]  TAIL_FL512_B = 8'h5F;           // "_"
  localparam logic [7:0]  TAIL_FLASH   = 8'h48;           // "H"
  localparam logic [31:0] TAIL_SIIRTC  = 32'h565F_4354;   // "TC_V"

  // Test one word-aligned position: w0 at the position, w1 and w2 after it.
  function automatic scan_st_t test_pos(logic [31:0] w0, logic [31:0] w1,
                                        logic [31:0] w2, scan_st_t s);
    scan_st_t r;
    r = s;
    unique case (w0)
      SIG_EEPR: begin
        if (w1[23:0] == TAIL_EEPROM &&
            (s.kind == KIND_NONE || s.kind == KIND_FLASH_GEN)) begin
          r.kind = KIND_EEPROM;
        end
      end
      SIG_SRAM: begin
        if (w1[7:0] == TAIL_SRAM &&
            (s.kind == KIND_NONE || s.kind == KIND_EEPROM ||
             s.kind == KIND_FLASH_GEN)) begin
          r.kind = KIND_SRAM;
        end
      end
      SIG_FLAS: begin
        if (s.kind == KIND_NONE) begin
          priority if (w1 == TAIL_FLASH1M) begin
            r.kind      = KIND_FLASH;
            r.big_flash = 1'b1;
          end else if (w1 == TAIL_FL512_A && w2[7:0] == TAIL_FL512_B) begin
            r.kind      = KIND_FLASH;
            r.big_flash = 1'b0;
          end else if (w1[7:0] == TAIL_FLASH) begin
            r.kind      = KIND_FLASH_GEN;
            r.big_flash = 1'b0;
          end else begin
            r.kind      = s.kind;
          end
        end
      end
      SIG_SIIR: begin
        if (w1 == TAIL_SIIRTC) begin
          r.clock_seen = 1'b1;
        end
      end
      default: begin
        r = s;
      end
    endcase
    return r;
  endfunction

  function automatic logic [1:0] save_code(kind_t k);
    logic [1:0] c;
    unique case (k)
      KIND_EEPROM:               c = SAVE_EEPROM;
      KIND_SRAM:                 c = SAVE_SRAM;
      KIND_FLASH, KIND_FLASH_GEN: c = SAVE_FLASH;
      default:                   c = SAVE_NONE;
    endcase
    return c;
  endfunction

endpackage

### hdl/rsss_if.sv
`timescale 1ns / 1ps

interface rsss_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] rom_word;
  logic        last_word;

  modport source (output valid, output rom_word, output last_word, input ready);
  modport sink   (input valid, input rom_word, input last_word, output ready);
endinterface

interface rsss_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] save_type;
  logic       flash_large;
  logic       clock_chip_found;

  modport source (output valid, output save_type, output flash_large,
                  output clock_chip_found, input ready);
  modport sink   (input valid, input save_type, input flash_large,
                  input clock_chip_found, output ready);
endinterface

### hdl/rom_save_signature_scanner_unit.sv
`timescale 1ns / 1ps
// A last word is held in the input register and its result is registered before it shows on out_ch.
// Throughput: one ROM word per cycle; the scan runs in a single stage between
// the input register and the state/result registers.
// A pending result stalls only a following last word, not ordinary words.
// Reset (rst_n low, synchronous): all scan state cleared, both channels empty.
module rom_save_signature_scanner_unit (
  input  logic      clk,
  input  logic      rst_n,
  rsss_in_if.sink   in_ch,
  rsss_out_if.source out_ch
);
  import rsss_pkg::*;

  logic        in_valid_r;
  logic [31:0] in_word_r;
  logic        in_last_r;

  logic [31:0] older_r;
  logic [31:0] older_nxt;
  logic [31:0] newer_r;
  logic [31:0] newer_nxt;
  scan_st_t    st_r;
  scan_st_t    st_nxt;
  scan_st_t    st_scan;

  logic        out_valid_r;
  logic        out_valid_nxt;
  logic [1:0]  save_type_r;
  logic        flash_large_r;
  logic        clock_found_r;

  logic        adv;

  rsss_match u_match (
    .older_word (older_r),
    .newer_word (newer_r),
    .word       (in_word_r),
    .last_word  (in_last_r),
    .st_in      (st_r),
    .st_out     (st_scan)
  );

  // Only a last word needs a free result slot.
  assign adv = in_valid_r && (!in_last_r || !out_valid_r || out_ch.ready);
  assign in_ch.ready = !in_valid_r || adv;

  always_comb begin
    older_nxt     = older_r;
    newer_nxt     = newer_r;
    st_nxt        = st_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    if (adv) begin
      if (in_last_r) begin
        older_nxt     = 32'h0;
        newer_nxt     = 32'h0;
        st_nxt        = SCAN_ST_RESET;
        out_valid_nxt = 1'b1;
      end else begin
        older_nxt = newer_r;
        newer_nxt = in_word_r;
        st_nxt    = st_scan;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      older_r     <= 32'h0;
      newer_r     <= 32'h0;
      st_r        <= SCAN_ST_RESET;
    end else begin
      if (in_ch.ready) begin
        in_valid_r <= in_ch.valid;
      end
      out_valid_r <= out_valid_nxt;
      older_r     <= older_nxt;
      newer_r     <= newer_nxt;
      st_r        <= st_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      in_word_r <= in_ch.rom_word;
      in_last_r <= in_ch.last_word;
    end
    if (adv && in_last_r) begin
      save_type_r   <= save_code(st_scan.kind);
      flash_large_r <= st_scan.big_flash;
      clock_found_r <= st_scan.clock_seen;
    end
  end

  assign out_ch.valid            = out_valid_r;
  assign out_ch.save_type        = save_type_r;
  assign out_ch.flash_large      = flash_large_r;
  assign out_ch.clock_chip_found = clock_found_r;

  // After a result is loaded the scan restarts from a clean state.
  a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && in_last_r) |=> (st_r == SCAN_ST_RESET && older_r == 32'h0 &&
                            newer_r == 32'h0 && out_valid_r))
    else $error("scan state not cleared after last word");

  // A waiting result is never overwritten.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ch.ready && in_valid_r && in_last_r) |-> !adv)
    else $error("pending result overwritten");

  // The large-flash flag only ever comes with a sized flash.
  a_big_is_flash: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.big_flash |-> (st_r.kind == KIND_FLASH))
    else $error("big_flash set without sized flash");

  // Words shift through the history only on non-last transfers.
  a_history_shift: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && !in_last_r) |=> (older_r == $past(newer_r) && newer_r == $past(in_word_r)))
    else $error("word history shifted incorrectly");

endmodule

### hdl/rsss_match.sv
`timescale 1ns / 1ps

module rsss_match (
  input  logic               [31:0] older_word,
  input  logic               [31:0] newer_word,
  input  logic               [31:0] word,
  input  logic                      last_word,
  input  rsss_pkg::scan_st_t        st_in,
  output rsss_pkg::scan_st_t        st_out
);
  import rsss_pkg::*;

  scan_st_t st_a;
  scan_st_t st_b;
  scan_st_t st_c;

  // Position two words back is complete now; on the last word the two
  // trailing positions follow, padded with zero bytes, in ROM order.
  always_comb begin
    st_a = test_pos(older_word, newer_word, word, st_in);
    st_b = test_pos(newer_word, word, 32'h0, st_a);
    st_c = test_pos(word, 32'h0, 32'h0, st_b);
    st_out = last_word ? st_c : st_a;
  end

endmodule

### sim/rom_save_signature_scanner_unit_tb.sv
`timescale 1ns / 1ps

module rom_save_signature_scanner_unit_tb;
  import rsss_pkg::*;

  localparam int RANDOM_WORDS = 1250;
  localparam int STALL_LIMIT  = 5000;
  localparam int DRAIN_CYCLES = 8;

  // real-time clock tag "SIIRTC_V", first character in the top byte of its 8-byte field
  localparam logic [71:0] RTC_TAG_STR = 72'h00_5349_4952_5443_5F56;

  typedef struct packed {
    logic [31:0] word;
    logic        last;
  } rom_item_t;

  typedef struct packed {
    logic [1:0] save_type;
    logic       flash_large;
    logic       clock_chip_found;
  } save_report_t;

  typedef enum int {
    SG_EEPROM, SG_SRAM, SG_FLASH1M, SG_FLASH512, SG_FLASH, SG_RTC, SG_COUNT
  } sig_sel_t;

  logic clk;
  logic rst_n;

  rsss_in_if  in_ch();
  rsss_out_if out_ch();

  rom_save_signature_scanner_unit dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  rom_item_t    word_feed[$];
  logic [31:0]  image_words[$];
  save_report_t pending_reports[$];

  int words_taken = 0;
  int words_total = 0;
  int mismatches  = 0;
  int stall_count = 0;
  logic in_taken;

  // scanner shadow state
  logic [31:0] prev2_word;
  logic [31:0] prev1_word;
  kind_t       seen_kind;
  logic        seen_big_flash;
  logic        seen_clock;

  // ---------------------------------------------------------------- predictor
  // Byte k of the window is bits 8k+7:8k; the string literal holds its first
  // character in the top byte of its n-byte field.
  function automatic bit window_has(logic [95:0] win, logic [71:0] str, int n);
    for (int k = 0; k < n; k++) begin
      if (win[8*k +: 8] != str[8*(n-1-k) +: 8]) return 1'b0;
    end
    return 1'b1;
  endfunction

  task automatic scan_position(logic [31:0] w0, logic [31:0] w1, logic [31:0] w2);
    logic [95:0] win;
    win = {w2, w1, w0};
    if (window_has(win, "EEPROM_", 7)) begin
      if (seen_kind == KIND_NONE || seen_kind == KIND_FLASH_GEN) seen_kind = KIND_EEPROM;
    end else if (window_has(win, "SRAM_", 5)) begin
      if (seen_kind == KIND_NONE || seen_kind == KIND_EEPROM ||
          seen_kind == KIND_FLASH_GEN) seen_kind = KIND_SRAM;
    end else if (window_has(win, "FLASH1M_", 8)) begin
      if (seen_kind == KIND_NONE) begin
        seen_kind      = KIND_FLASH;
        seen_big_flash = 1'b1;
      end
    end else if (window_has(win, "FLASH512_", 9)) begin
      if (seen_kind == KIND_NONE) begin
        seen_kind      = KIND_FLASH;
        seen_big_flash = 1'b0;
      end
    end else if (window_has(win, "FLASH", 5)) begin
      if (seen_kind == KIND_NONE) begin
        seen_kind      = KIND_FLASH_GEN;
        seen_big_flash = 1'b0;
      end
    end else if (window_has(win, RTC_TAG_STR, 8)) begin
      seen_clock = 1'b1;
    end
  endtask

  task automatic clear_scan();
    prev2_word     = '0;
    prev1_word     = '0;
    seen_kind      = KIND_NONE;
    seen_big_flash = 1'b0;
    seen_clock     = 1'b0;
  endtask

  task automatic predict_word(logic [31:0] w, logic last);
    save_report_t rep;
    scan_position(prev2_word, prev1_word, w);
    if (!last) begin
      prev2_word = prev1_word;
      prev1_word = w;
    end else begin
      // trailing positions see zero bytes past the end
      scan_position(prev1_word, w, 32'h0);
      scan_position(w, 32'h0, 32'h0);
      case (seen_kind)
        KIND_EEPROM:                 rep.save_type = SAVE_EEPROM;
        KIND_SRAM:                   rep.save_type = SAVE_SRAM;
        KIND_FLASH, KIND_FLASH_GEN:  rep.save_type = SAVE_FLASH;
        default:                     rep.save_type = SAVE_NONE;
      endcase
      rep.flash_large      = seen_big_flash;
      rep.clock_chip_found = seen_clock;
      pending_reports.push_back(rep);
      clear_scan();
    end
  endtask

  // ---------------------------------------------------------------- stimulus
  function automatic logic [31:0] noise_word();
    int pick;
    pick = $urandom_range(9);
    if (pick == 0) return 32'h0000_0000;
    if (pick == 1) return 32'hFFFF_FFFF;
    return $urandom;
  endfunction

  task automatic add_signature(sig_sel_t sel);
    logic [31:0] r;
    r = $urandom;
    case (sel)
      SG_EEPROM: begin
        image_words.push_back(SIG_EEPR);
        image_words.push_back({r[31:24], TAIL_EEPROM});
      end
      SG_SRAM: begin
        image_words.push_back(SIG_SRAM);
        image_words.push_back({r[31:8], TAIL_SRAM});
      end
      SG_FLASH1M: begin
        image_words.push_back(SIG_FLAS);
        image_words.push_back(TAIL_FLASH1M);
      end
      SG_FLASH512: begin
        image_words.push_back(SIG_FLAS);
        image_words.push_back(TAIL_FL512_A);
        image_words.push_back({r[31:8], TAIL_FL512_B});
      end
      SG_FLASH: begin
        image_words.push_back(SIG_FLAS);
        image_words.push_back({r[31:8], TAIL_FLASH});
      end
      default: begin
        image_words.push_back(SIG_SIIR);
        image_words.push_back(TAIL_SIIRTC);
      end
    endcase
  endtask

  // Queue the collected image, last marker on its final word.
  task automatic flush_image();
    rom_item_t it;
    for (int i = 0; i < image_words.size(); i++) begin
      it.word = image_words[i];
      it.last = (i == image_words.size() - 1);
      word_feed.push_back(it);
    end
    image_words.delete();
  endtask

  task automatic add_broken_signature();
    sig_sel_t sel;
    int       span;
    int       idx;
    sel = sig_sel_t'($urandom_range(SG_COUNT - 1));
    add_signature(sel);
    span = (sel == SG_FLASH512) ? 3 : 2;
    idx  = image_words.size() - 1 - $urandom_range(span - 1);
    image_words[idx] = image_words[idx] ^ (32'h1 << $urandom_range(31));
  endtask

  task automatic add_random_image();
    int tokens;
    int pick;
    tokens = ($urandom_range(9) == 0) ? $urandom_range(11, 40) : $urandom_range(1, 10);
    for (int t = 0; t < tokens; t++) begin
      pick = $urandom_range(99);
      if (pick < 55)      add_signature(sig_sel_t'($urandom_range(SG_COUNT - 1)));
      else if (pick < 70) add_broken_signature();
      else                image_words.push_back(noise_word());
    end
    flush_image();
  endtask

  task automatic build_directed();
    // one-word image
    image_words.push_back($urandom);
    flush_image();
    // "FLAS" alone: the bytes after it are zero, nothing matches
    image_words.push_back(SIG_FLAS);
    flush_image();
    // signature ending on the last word
    add_signature(SG_EEPROM);
    flush_image();
    image_words.push_back(32'hFFFF_FFFF);
    add_signature(SG_SRAM);
    image_words.push_back(32'h0000_0000);
    flush_image();
    add_signature(SG_FLASH1M);
    flush_image();
    // FLASH512_ cut short by the end: falls back to generic flash
    add_signature(SG_FLASH512);
    void'(image_words.pop_back());
    flush_image();
    add_signature(SG_FLASH512);
    flush_image();
    add_signature(SG_FLASH);
    flush_image();
    add_signature(SG_RTC);
    flush_image();
    // upgrades: generic flash -> eeprom -> sram, plus clock
    add_signature(SG_FLASH);
    add_signature(SG_EEPROM);
    add_signature(SG_RTC);
    add_signature(SG_SRAM);
    flush_image();
    // sized flash blocks later eeprom and sram
    add_signature(SG_FLASH1M);
    add_signature(SG_EEPROM);
    add_signature(SG_SRAM);
    flush_image();
    // sram blocks eeprom and flash
    add_signature(SG_SRAM);
    add_signature(SG_EEPROM);
    add_signature(SG_FLASH512);
    flush_image();
    // eeprom blocks flash
    add_signature(SG_EEPROM);
    add_signature(SG_FLASH1M);
    flush_image();
    image_words.push_back(32'hFFFF_FFFF);
    image_words.push_back(32'h0000_0000);
    flush_image();
    add_broken_signature();
    add_broken_signature();
    flush_image();
  endtask

  // ---------------------------------------------------------------- idling
  function automatic int sender_idle_pct();
    if (words_taken < words_total / 3)     return 18;
    if (words_taken < 2 * words_total / 3) return 45;
    return 0;
  endfunction

  function automatic int receiver_idle_pct();
    if (words_taken < words_total / 3)     return 45;
    if (words_taken < 2 * words_total / 3) return 18;
    return 0;
  endfunction

  // ---------------------------------------------------------------- driver
  always @(negedge clk) begin
    rom_item_t it;
    if (!rst_n) begin
      in_ch.valid  <= 1'b0;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= receiver_idle_pct());
      if (!in_ch.valid || in_taken) begin
        if (word_feed.size() > 0 && $urandom_range(99) >= sender_idle_pct()) begin
          it = word_feed.pop_front();
          in_ch.valid     <= 1'b1;
          in_ch.rom_word  <= it.word;
          in_ch.last_word <= it.last;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------- monitor
  always @(posedge clk) begin
    save_report_t got;
    save_report_t want;
    if (!rst_n) begin
      in_taken    <= 1'b0;
      stall_count = 0;
      clear_scan();
    end else begin
      in_taken <= in_ch.valid && in_ch.ready;
      if (in_ch.valid && in_ch.ready) begin
        predict_word(in_ch.rom_word, in_ch.last_word);
        words_taken++;
      end
      if (out_ch.valid && out_ch.ready) begin
        got.save_type        = out_ch.save_type;
        got.flash_large      = out_ch.flash_large;
        got.clock_chip_found = out_ch.clock_chip_found;
        if (pending_reports.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result: type=%0d large=%0b rtc=%0b",
                     got.save_type, got.flash_large, got.clock_chip_found);
        end else begin
          want = pending_reports.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: type exp %0d got %0d, large exp %0b got %0b, rtc exp %0b got %0b",
                       want.save_type, got.save_type, want.flash_large, got.flash_large,
                       want.clock_chip_found, got.clock_chip_found);
          end
        end
      end
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
        stall_count = 0;
      end else begin
        stall_count++;
        if (stall_count >= STALL_LIMIT) begin
          $display("rom_save_signature_scanner_unit_tb NOT OK");
          $finish;
        end
      end
    end
  end

  // ---------------------------------------------------------------- sequence
  initial begin
    rst_n            = 1'b0;
    in_ch.valid      = 1'b0;
    in_ch.rom_word   = '0;
    in_ch.last_word  = 1'b0;
    out_ch.ready     = 1'b0;
    build_directed();
    while (word_feed.size() < RANDOM_WORDS + 60) add_random_image();
    words_total = word_feed.size();
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    while (words_taken < words_total) @(posedge clk);
    while (pending_reports.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("rom_save_signature_scanner_unit_tb OK");
    end else begin
      $display("rom_save_signature_scanner_unit_tb NOT OK");
    end
    $finish;
  end

endmodule
